/* src/barycentric_depth_unit_assert.svh */
// Assertion macros shared by the block's modules.
`ifndef BARYCENTRIC_DEPTH_UNIT_ASSERT_SVH
`define BARYCENTRIC_DEPTH_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define BDU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define BDU_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* src/bdu_pkg.sv */
package bdu_pkg;

  localparam int WFB    = 16;            // fraction bits of weights and depth
  localparam int OUT_W  = 24;
  localparam int QW     = OUT_W - 1;     // quotient bits below saturation
  localparam int SAT_SH = OUT_W - 1 - WFB;
  localparam int NW     = 35;            // exact width of k and the numerators
  localparam int RW     = NW + QW;       // divider remainder width

  localparam logic signed [OUT_W-1:0] ONE     = OUT_W'(1) << WFB;
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [15:0] v0_x;
    logic signed [15:0] v0_y;
    logic signed [15:0] v1_x;
    logic signed [15:0] v1_y;
    logic signed [15:0] v2_x;
    logic signed [15:0] v2_y;
    logic signed [15:0] pt_x;
    logic signed [15:0] pt_y;
    logic signed [15:0] z0;
    logic signed [15:0] z1;
    logic signed [15:0] z2;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] w0;
    logic signed [OUT_W-1:0] w1;
    logic signed [OUT_W-1:0] w2;
    logic signed [OUT_W-1:0] depth;
    logic                    degenerate;
    logic                    saturated;
  } out_t;

  // Side information that travels with an item through the divider.
  typedef struct packed {
    logic               degen;
    logic               zero_b;
    logic               zero_c;
    logic               sat_b;
    logic               sat_c;
    logic signed [16:0] h0;
    logic signed [16:0] h1;
    logic signed [16:0] h2;
  } side_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic [NW-1:0] num_b;
    logic [NW-1:0] num_c;
    logic [NW-1:0] den;
    side_t         side;
  } cls_t;

endpackage

/* src/bdu_front.sv */
module bdu_front import bdu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic enable,
  input  logic take,
  input  in_t  item,
  output logic push,
  output cls_t cls
);

  logic               s1_v, s2_v, s3_v;
  logic signed [16:0] ax, ay, bx, by, nx, ny;
  logic signed [16:0] h0_1, h1_1, h2_1, h0_2, h1_2, h2_2, h0_3, h1_3, h2_3;
  logic signed [33:0] p_axby, p_bxay, p_bynx, p_bxny, p_axny, p_aynx;
  logic signed [NW-1:0] k, nb, nc;
  logic [NW-1:0]      k_mag, nb_mag, nc_mag;
  logic               zb, zc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (enable) begin
      s1_v <= take;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      ax   <= 17'(item.v1_x) - 17'(item.v0_x);
      ay   <= 17'(item.v1_y) - 17'(item.v0_y);
      bx   <= 17'(item.v2_x) - 17'(item.v0_x);
      by   <= 17'(item.v2_y) - 17'(item.v0_y);
      nx   <= 17'(item.pt_x) - 17'(item.v0_x);
      ny   <= 17'(item.pt_y) - 17'(item.v0_y);
      h0_1 <= 17'(item.z0) + 17'sd16384;
      h1_1 <= 17'(item.z1) + 17'sd16384;
      h2_1 <= 17'(item.z2) + 17'sd16384;

      p_axby <= 34'(ax) * 34'(by);
      p_bxay <= 34'(bx) * 34'(ay);
      p_bynx <= 34'(by) * 34'(nx);
      p_bxny <= 34'(bx) * 34'(ny);
      p_axny <= 34'(ax) * 34'(ny);
      p_aynx <= 34'(ay) * 34'(nx);
      h0_2 <= h0_1;
      h1_2 <= h1_1;
      h2_2 <= h2_1;

      k    <= NW'(p_axby) - NW'(p_bxay);
      nb   <= NW'(p_bynx) - NW'(p_bxny);
      nc   <= NW'(p_axny) - NW'(p_aynx);
      h0_3 <= h0_2;
      h1_3 <= h1_2;
      h2_3 <= h2_2;
    end
  end

  // A numerator of zero or of the opposite sign to k gives a weight of zero.
  always_comb begin
    k_mag  = k[NW-1]  ? NW'(-k)  : NW'(k);
    nb_mag = nb[NW-1] ? NW'(-nb) : NW'(nb);
    nc_mag = nc[NW-1] ? NW'(-nc) : NW'(nc);
    zb = (nb == '0) || (nb[NW-1] != k[NW-1]);
    zc = (nc == '0) || (nc[NW-1] != k[NW-1]);
    cls.num_b       = nb_mag;
    cls.num_c       = nc_mag;
    cls.den         = k_mag;
    cls.side.degen  = (k == '0);
    cls.side.zero_b = zb;
    cls.side.zero_c = zc;
    // The quotient overflows exactly when n >= d * 2^SAT_SH.
    cls.side.sat_b  = !zb && ({{SAT_SH{1'b0}}, nb_mag} >= {k_mag, {SAT_SH{1'b0}}});
    cls.side.sat_c  = !zc && ({{SAT_SH{1'b0}}, nc_mag} >= {k_mag, {SAT_SH{1'b0}}});
    cls.side.h0     = h0_3;
    cls.side.h1     = h1_3;
    cls.side.h2     = h2_3;
    push = s3_v && enable;
  end

endmodule

/* src/bdu_fifo.sv */
module bdu_fifo import bdu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cls_t wdata,
  input  logic pop,
  output cls_t rdata,
  output logic empty,
  output logic full
);

  `include "barycentric_depth_unit_assert.svh"

  cls_t       entries [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign rdata = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= wdata;
  end

  `BDU_NEVER(a_no_overflow, push && full && !pop, "queue overflow")
  `BDU_NEVER(a_no_underflow, pop && empty, "queue underflow")
  `BDU_NEVER(a_count_range, count == 2'd3, "queue count out of range")

endmodule

/* src/bdu_back.sv */
module bdu_back import bdu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  cls_t cls,
  output logic strobe,
  output out_t result
);

  // Divider lanes for u and v share the divisor; stage g settles quotient bit QW-1-g.
  logic          dv   [QW+1];
  logic [RW-1:0] rb   [QW+1];
  logic [RW-1:0] rc   [QW+1];
  logic [QW-1:0] qb   [QW+1];
  logic [QW-1:0] qc   [QW+1];
  logic [NW-1:0] den  [QW+1];
  side_t         side [QW+1];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else     dv[0] <= take;
  end

  always_ff @(posedge clk) begin
    rb[0]   <= RW'({cls.num_b, {WFB{1'b0}}});
    rc[0]   <= RW'({cls.num_c, {WFB{1'b0}}});
    qb[0]   <= '0;
    qc[0]   <= '0;
    den[0]  <= cls.den;
    side[0] <= cls.side;
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    logic [RW-1:0] dsh;
    logic          gb, gc;
    always_comb begin
      dsh = RW'(den[g]) << (QW - 1 - g);
      gb  = (rb[g] >= dsh);
      gc  = (rc[g] >= dsh);
    end
    always_ff @(posedge clk) begin
      if (rst) dv[g+1] <= 1'b0;
      else     dv[g+1] <= dv[g];
    end
    always_ff @(posedge clk) begin
      rb[g+1]   <= gb ? rb[g] - dsh : rb[g];
      rc[g+1]   <= gc ? rc[g] - dsh : rc[g];
      qb[g+1]   <= {qb[g][QW-2:0], gb};
      qc[g+1]   <= {qc[g][QW-2:0], gc};
      den[g+1]  <= den[g];
      side[g+1] <= side[g];
    end
  end

  // Weights.
  side_t                   sd;
  logic signed [OUT_W-1:0] b_w, c_w, a_w;
  logic signed [OUT_W+1:0] a_full;
  logic                    a_clip;
  logic                    wv, wsat, wdeg;
  logic signed [OUT_W-1:0] wa, wb, wc;
  logic signed [16:0]      wh0, wh1, wh2;

  always_comb begin
    sd     = side[QW];
    b_w    = sd.zero_b ? '0 : (sd.sat_b ? OUT_MAX : OUT_W'(qb[QW]));
    c_w    = sd.zero_c ? '0 : (sd.sat_c ? OUT_MAX : OUT_W'(qc[QW]));
    a_full = (OUT_W+2)'(ONE) - (OUT_W+2)'(b_w) - (OUT_W+2)'(c_w);
    a_clip = (a_full > (OUT_W+2)'(OUT_MAX)) || (a_full < (OUT_W+2)'(OUT_MIN));
    if (a_full > (OUT_W+2)'(OUT_MAX))      a_w = OUT_MAX;
    else if (a_full < (OUT_W+2)'(OUT_MIN)) a_w = OUT_MIN;
    else                                   a_w = OUT_W'(a_full);
  end

  always_ff @(posedge clk) begin
    if (rst) wv <= 1'b0;
    else     wv <= dv[QW];
  end

  always_ff @(posedge clk) begin
    wdeg <= sd.degen;
    if (sd.degen) begin
      wa   <= -ONE;
      wb   <= ONE;
      wc   <= ONE;
      wsat <= 1'b0;
    end else begin
      wa   <= a_w;
      wb   <= b_w;
      wc   <= c_w;
      wsat <= sd.sat_b || sd.sat_c || a_clip;
    end
    wh0 <= sd.h0;
    wh1 <= sd.h1;
    wh2 <= sd.h2;
  end

  // Depth: products, sum, then round half up by the arithmetic shift and clip.
  logic                    mv, sv;
  logic signed [40:0]      p0, p1, p2;
  logic signed [42:0]      sum;
  logic signed [OUT_W-1:0] ma, mb, mc, sa, sb, sc;
  logic                    msat, mdeg, ssat, sdeg;
  logic signed [27:0]      dq;
  logic                    d_hi, d_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv     <= 1'b0;
      sv     <= 1'b0;
      strobe <= 1'b0;
    end else begin
      mv     <= wv;
      sv     <= mv;
      strobe <= sv;
    end
  end

  always_ff @(posedge clk) begin
    p0   <= 41'(wa) * 41'(wh0);
    p1   <= 41'(wb) * 41'(wh1);
    p2   <= 41'(wc) * 41'(wh2);
    ma   <= wa;
    mb   <= wb;
    mc   <= wc;
    msat <= wsat;
    mdeg <= wdeg;

    sum  <= 43'(p0) + 43'(p1) + 43'(p2) + 43'sd16384;
    sa   <= ma;
    sb   <= mb;
    sc   <= mc;
    ssat <= msat;
    sdeg <= mdeg;
  end

  always_comb begin
    dq   = 28'(sum >>> 15);
    d_hi = dq > 28'(OUT_MAX);
    d_lo = dq < 28'(OUT_MIN);
  end

  always_ff @(posedge clk) begin
    result.w0         <= sa;
    result.w1         <= sb;
    result.w2         <= sc;
    result.depth      <= d_hi ? OUT_MAX : (d_lo ? OUT_MIN : OUT_W'(dq));
    result.degenerate <= sdeg;
    result.saturated  <= ssat || d_hi || d_lo;
  end

endmodule

/* src/barycentric_depth_unit.sv */
// Channel   Handshake          Payload
// item      start / busy       item  (bdu_pkg::in_t)
// result    strobe             result (bdu_pkg::out_t)
//
// One beat is accepted per cycle; each beat produces one result, in the order of the beats.
// The core is the 23-stage restoring divider, one quotient bit per stage.
// Reset clears all valid flags and the queue pointers.
// The result side cannot stall; busy rises only if the queue between front and
// back were full, so the block runs at one beat per cycle.
module barycentric_depth_unit import bdu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  item,
  output logic strobe,
  output out_t result
);

  `include "barycentric_depth_unit_assert.svh"

  logic push, empty, full;
  cls_t cls_in, cls_out;

  assign busy = full;

  bdu_front u_front (
    .clk    (clk),
    .rst    (rst),
    .enable (!full),
    .take   (start && !busy),
    .item   (item),
    .push   (push),
    .cls    (cls_in)
  );

  bdu_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls_in),
    .pop   (!empty),
    .rdata (cls_out),
    .empty (empty),
    .full  (full)
  );

  bdu_back u_back (
    .clk    (clk),
    .rst    (rst),
    .take   (!empty),
    .cls    (cls_out),
    .strobe (strobe),
    .result (result)
  );

  `BDU_ASSERT(a_degen_weights, strobe && result.degenerate |->
    result.w0 == -ONE && result.w1 == ONE && result.w2 == ONE, "bad degenerate weights")
  `BDU_ASSERT(a_weights_nonneg, strobe |-> !result.w1[OUT_W-1] && !result.w2[OUT_W-1],
    "negative u or v weight")
  // The back end drains a beat every cycle, so the queue never fills.
  `BDU_NEVER(a_never_busy, busy, "queue filled while the back end drains every cycle")

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import bdu_pkg::*;

  localparam int N_RANDOM   = 1850;
  localparam int LATENCY    = 32;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_t  item = '0;
  logic strobe;
  out_t result;

  barycentric_depth_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .strobe(strobe), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  out_t pending_weights[$];
  int   errors = 0;
  int   cycles = 0;

  function automatic logic signed [63:0] clip_out(input logic signed [63:0] x,
                                                  inout logic sat);
    if (x > 64'sd8388607) begin
      sat = 1'b1;
      return 64'sd8388607;
    end
    if (x < -64'sd8388608) begin
      sat = 1'b1;
      return -64'sd8388608;
    end
    return x;
  endfunction

  // Nonnegative part of num/den with WFB fraction bits, truncated.
  function automatic logic signed [63:0] pos_ratio(input logic signed [63:0] num,
                                                   input logic signed [63:0] den,
                                                   inout logic sat);
    logic [63:0] n, d, q;
    if (num == 0 || ((num < 0) != (den < 0))) return 0;
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = (n << WFB) / d;
    if (q > 64'd8388607) begin
      sat = 1'b1;
      return 64'sd8388607;
    end
    return $signed(q);
  endfunction

  function automatic out_t predict_weights(input in_t it);
    logic signed [63:0] ax, ay, bx, by, nx, ny, k, a, b, c, s, q, h0, h1, h2, one;
    logic sat;
    out_t r;
    sat = 1'b0;
    one = 64'sd1 <<< WFB;
    ax = it.v1_x - it.v0_x;
    ay = it.v1_y - it.v0_y;
    bx = it.v2_x - it.v0_x;
    by = it.v2_y - it.v0_y;
    nx = it.pt_x - it.v0_x;
    ny = it.pt_y - it.v0_y;
    h0 = 64'(it.z0) + 16384;
    h1 = 64'(it.z1) + 16384;
    h2 = 64'(it.z2) + 16384;
    k = ax * by - bx * ay;
    if (k == 0) begin
      a = -one;
      b = one;
      c = one;
    end else begin
      b = pos_ratio(by * nx - bx * ny, k, sat);
      c = pos_ratio(ax * ny - ay * nx, k, sat);
      a = clip_out(one - b - c, sat);
    end
    s = a * h0 + b * h1 + c * h2 + (64'sd1 <<< 14);
    if (s >= 0) q = s >>> 15;
    else q = -((-s + 32767) >>> 15);
    q = clip_out(q, sat);
    r.w0 = a[23:0];
    r.w1 = b[23:0];
    r.w2 = c[23:0];
    r.depth = q[23:0];
    r.degenerate = (k == 0);
    r.saturated = sat;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [23:0] exp_v,
                             input logic signed [23:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_t e;
    if (!rst && strobe) begin
      if (pending_weights.size() == 0) begin
        $error("result beat with no expectation waiting");
        errors++;
      end else begin
        e = pending_weights.pop_front();
        check_field("w0", e.w0, result.w0);
        check_field("w1", e.w1, result.w1);
        check_field("w2", e.w2, result.w2);
        check_field("depth", e.depth, result.depth);
        check_field("degenerate", 24'(e.degenerate), 24'(result.degenerate));
        check_field("saturated", 24'(e.saturated), 24'(result.saturated));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL barycentric_depth_unit");
      $finish;
    end
  end

  typedef struct {
    in_t  it;
    bit   typed;
    out_t res;
  } stim_row_t;

  stim_row_t directed[$];

  function automatic in_t tri_item(int x0, int y0, int x1, int y1, int x2, int y2,
                                   int px, int py, int z0, int z1, int z2);
    in_t t;
    t.v0_x = x0; t.v0_y = y0; t.v1_x = x1; t.v1_y = y1;
    t.v2_x = x2; t.v2_y = y2; t.pt_x = px; t.pt_y = py;
    t.z0 = z0; t.z1 = z1; t.z2 = z2;
    return t;
  endfunction

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 2047)) - 1024);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_z();
    case ($urandom_range(0, 7))
      0: return -16'sd16384;
      1: return 16'sd16384;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic in_t random_item();
    in_t t;
    t = tri_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_z(), rand_z(), rand_z());
    // Now and then collapse the triangle so the determinant is zero, or put the point on vertex 0.
    case ($urandom_range(0, 9))
      0: begin t.v1_x = t.v0_x; t.v1_y = t.v0_y; end
      1: begin t.v2_x = t.v1_x; t.v2_y = t.v1_y; end
      2: begin t.pt_x = t.v0_x; t.pt_y = t.v0_y; end
      default: ;
    endcase
    return t;
  endfunction

  // Holds an item for one beat; the valid stays high across back-to-back beats.
  // Called at a falling edge, where busy shows the value for the coming edge.
  task automatic send_beat(input in_t it, input bit keep);
    bit stalled;
    item  <= it;
    start <= 1'b1;
    stalled = busy;
    @(posedge clk);
    while (stalled) begin
      @(negedge clk);
      stalled = busy;
      @(posedge clk);
    end
    pending_weights.push_back(predict_weights(it));
    @(negedge clk);
    if (!keep) start <= 1'b0;
  endtask

  initial begin
    stim_row_t row;
    out_t exp_r;
    int burst, gap, wait_cycles;

    // Right triangle with legs of 16; point at each vertex gives pure weights.
    row.typed = 1'b1;
    row.it = tri_item(0, 0, 16, 0, 0, 16, 0, 0, -16384, 0, 16384);
    row.res = '{w0: ONE, w1: 0, w2: 0, depth: 0, degenerate: 0, saturated: 0};
    directed.push_back(row);
    row.it = tri_item(0, 0, 16, 0, 0, 16, 16, 0, -16384, 0, 16384);
    row.res = '{w0: 0, w1: ONE, w2: 0, depth: 24'sd32768, degenerate: 0, saturated: 0};
    directed.push_back(row);
    row.it = tri_item(0, 0, 16, 0, 0, 16, 0, 16, -16384, 0, 16384);
    row.res = '{w0: 0, w1: 0, w2: ONE, depth: ONE, degenerate: 0, saturated: 0};
    directed.push_back(row);
    // Collapsed triangle: fixed weights, depth still from them.
    row.it = tri_item(5, 5, 5, 5, 5, 5, 0, 0, 16384, 16384, 16384);
    row.res = '{w0: -ONE, w1: ONE, w2: ONE, depth: ONE, degenerate: 1, saturated: 0};
    directed.push_back(row);
    row.typed = 1'b0;
    row.it = tri_item(-32768, -32768, 32767, -32768, -32768, 32767,
                      32767, 32767, -32768, 32767, 16384);
    directed.push_back(row);
    row.it = tri_item(0, 0, 1, 0, 0, 1, 32767, 32767, 16384, 16384, 16384);
    directed.push_back(row);
    row.it = tri_item(0, 0, 1, 0, 0, 1, -32768, -32768, -16384, -16384, -16384);
    directed.push_back(row);
    row.it = tri_item(0, 0, 32767, 0, 0, 32767, 1, 1, 0, 0, 0);
    directed.push_back(row);
    row.it = tri_item(0, 0, 16, 0, 0, 16, 5, 6, -32768, 32767, -1);
    directed.push_back(row);
    row.it = tri_item(0, 0, 0, 16, 16, 0, 3, 7, 100, -100, 16384);
    directed.push_back(row);
    row.it = tri_item(-1, -1, -1, -1, 32767, 32767, 7, 9, 32767, -32768, 0);
    directed.push_back(row);
    row.it = tri_item(1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11);
    directed.push_back(row);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The directed rows run back to back straight into the random part.
    foreach (directed[i]) begin
      send_beat(directed[i].it, 1'b1);
      if (directed[i].typed) begin
        exp_r = pending_weights[$];
        if (exp_r !== directed[i].res) begin
          $error("typed row %0d: predictor gives %h, table %h", i, exp_r,
                 directed[i].res);
          errors++;
        end
      end
    end

    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      for (int j = 0; j < burst && n < N_RANDOM; j++, n++)
        send_beat(random_item(), (j < burst - 1 || gap == 0) && n < N_RANDOM - 1);
      repeat (gap) @(negedge clk);
    end

    wait_cycles = 0;
    while (pending_weights.size() != 0 && wait_cycles < 10 * LATENCY) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY) @(posedge clk);
    if (pending_weights.size() != 0) begin
      $error("%0d expected results never arrived", pending_weights.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS barycentric_depth_unit");
    end else begin
      $display("FAIL barycentric_depth_unit");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/bdu_pkg.sv
src/bdu_front.sv
src/bdu_fifo.sv
src/bdu_back.sv
src/barycentric_depth_unit.sv
test/tb_top.sv
